@@ design/ipc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared constants and types for the isolated pixel counter: frame limits,
// field widths, register indexes and the line store word.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int SIZE_W  = 8;
    localparam int COUNT_W = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLUMNS = CFG_IDX_W'(1);

    // One line store word per column: bit 1 is two rows back, bit 0 one row back.
    typedef logic [1:0]       t_line_word;
    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;

endpackage

@@ design/ipc_line_store.sv @@
// ----------------------------------------------------------------------------
// ipc_line_store
// Column-addressed store of the two previous rows. One registered read and
// one write per cycle; a write to the address read in the same cycle is
// forwarded into the read data.
// ----------------------------------------------------------------------------
module ipc_line_store (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  ipc_pkg::t_col      i_rd_addr,
    output ipc_pkg::t_line_word o_rd_data,
    input  logic               i_wr_en,
    input  ipc_pkg::t_col      i_wr_addr,
    input  ipc_pkg::t_line_word i_wr_data
);
    import ipc_pkg::*;

    t_line_word r_mem [MAX_COLUMNS];
    t_line_word r_rd_q;
    t_line_word r_fwd_data;
    logic       r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_q;

endmodule

@@ design/isolated_pixel_counter_core.sv @@
// Isolated pixel counter: one pixel per cycle, sustained across row and frame ends unless a count is held back.
// The frame's count is registered into the output register once its last pixel leaves the window stage.
// Rate is set by the single read-modify-write of the line store per pixel; the input
// stalls only while a frame end waits behind a count the receiver is not taking.
// Synchronous active-low reset: sizes return to 128 and the frame restarts.
// A write to either size register also restarts the frame in progress.
// ----------------------------------------------------------------------------
// isolated_pixel_counter_core
// Counts set pixels with no set 8-neighbor in a raster binary frame using a
// 3x3 window fed by a two-row line store.
// ----------------------------------------------------------------------------
module isolated_pixel_counter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ipc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipc_pkg::SIZE_W-1:0]    i_cfg_data,
    // pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] is_set, [7:1] zero
    // count stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [12:0] isolated_count, [15:13] zero
);
    import ipc_pkg::*;

    typedef struct packed {
        t_col col;
        logic is_set;
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_col;
        logic last_row;
    } t_pix_info;

    // column bits: [2] top row, [1] middle row, [0] bottom row
    function automatic logic alone(input logic [2:0] l, input logic [2:0] m,
                                   input logic [2:0] r);
        return m[1] && !m[2] && !m[0] && (l == 3'b000) && (r == 3'b000);
    endfunction

    // move the window down one row: bottom becomes empty
    function automatic logic [2:0] shift_up(input logic [2:0] c);
        return {c[1], c[0], 1'b0};
    endfunction

    logic [SIZE_W-1:0] r_rows;
    logic [SIZE_W-1:0] r_cols;
    t_col              r_col;
    t_row              r_row;
    logic              r_s1_valid;
    t_pix_info         r_s1;
    logic [2:0]        r_w1;
    logic [2:0]        r_w2;
    logic [COUNT_W-1:0] r_count;
    logic              r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    t_col       last_col_idx;
    t_row       last_row_idx;
    logic       cfg_hit;
    logic       accept;
    logic       stall;
    logic       s1_adv;
    logic       frame_end;
    t_pix_info  n_info;
    t_line_word rd_word;
    logic [2:0] col0;
    logic [2:0] left_a;
    logic [2:0] left_b;
    logic       hit_a;
    logic       hit_b;
    logic       hit_c;
    logic       hit_d;
    logic [2:0] incs;
    logic [COUNT_W:0] sum;
    logic [COUNT_W-1:0] n_count;

    // clamp sizes: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (r_cols == '0) begin
            last_col_idx = '0;
        end else if (int'(r_cols) > MAX_COLUMNS) begin
            last_col_idx = COL_W'(MAX_COLUMNS - 1);
        end else begin
            last_col_idx = COL_W'(r_cols - SIZE_W'(1));
        end
        if (r_rows == '0) begin
            last_row_idx = '0;
        end else if (int'(r_rows) > MAX_ROWS) begin
            last_row_idx = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row_idx = ROW_W'(r_rows - SIZE_W'(1));
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == REG_FRAME_ROWS || i_cfg_index == REG_FRAME_COLUMNS);

    // hold the window stage while a frame end waits for the output register
    assign frame_end     = r_s1.last_col && r_s1.last_row;
    assign stall         = r_s1_valid && frame_end && r_out_valid && !m_axis_tready;
    assign s1_adv        = r_s1_valid && !stall;
    assign s_axis_tready = !stall;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_info.col      = r_col;
        n_info.is_set   = s_axis_tdata[0];
        n_info.row_ge1  = (r_row != '0);
        n_info.row_ge2  = (r_row > ROW_W'(1));
        n_info.col_ge1  = (r_col != '0);
        n_info.col_ge2  = (r_col > COL_W'(1));
        n_info.last_col = (r_col == last_col_idx);
        n_info.last_row = (r_row == last_row_idx);
    end

    ipc_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_word),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1.col),
        .i_wr_data ({rd_word[0], r_s1.is_set})
    );

    // rows not yet written in this frame read as empty
    assign col0   = {r_s1.row_ge2 & rd_word[1], r_s1.row_ge1 & rd_word[0], r_s1.is_set};
    assign left_a = r_s1.col_ge2 ? r_w2 : 3'b000;
    assign left_b = r_s1.col_ge1 ? r_w1 : 3'b000;

    always_comb begin
        // row above, center one column back
        hit_a = r_s1.col_ge1 && alone(left_a, r_w1, col0);
        // row above, center at the row's right edge
        hit_b = r_s1.last_col && alone(left_b, col0, 3'b000);
        // last row judged at once with nothing below it
        hit_c = r_s1.last_row && r_s1.col_ge1 &&
                alone(shift_up(left_a), shift_up(r_w1), shift_up(col0));
        hit_d = r_s1.last_row && r_s1.last_col &&
                alone(shift_up(left_b), shift_up(col0), 3'b000);
        incs = 3'({2'b00, hit_a}) + 3'({2'b00, hit_b}) +
               3'({2'b00, hit_c}) + 3'({2'b00, hit_d});
        sum = {1'b0, r_count} + (COUNT_W+1)'(incs);
        if (sum > (COUNT_W+1)'(COUNT_LIMIT)) begin
            n_count = COUNT_LIMIT;
        end else begin
            n_count = sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= SIZE_W'(128);
            r_cols      <= SIZE_W'(128);
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == REG_FRAME_ROWS) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == REG_FRAME_COLUMNS) begin
                r_cols <= i_cfg_data;
            end

            if (!stall) begin
                r_s1_valid <= accept;
            end

            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (n_info.last_col) begin
                    r_col <= '0;
                    r_row <= n_info.last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end

            if (cfg_hit) begin
                r_count <= '0;
            end else if (s1_adv) begin
                r_count <= frame_end ? '0 : n_count;
            end

            if (s1_adv && frame_end) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!stall && accept) begin
            r_s1 <= n_info;
        end
        if (s1_adv) begin
            r_w2 <= r_w1;
            r_w1 <= col0;
        end
        if (s1_adv && frame_end) begin
            r_out_count <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_count};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for isolated_pixel_counter_core. Binary frames of many
// sizes are streamed in raster order with random gaps and stalls. Every frame
// count that comes out is compared against a local model of the 3x3
// isolation test, or against the count given in the directed plan.
// ----------------------------------------------------------------------------
module tb;
    import ipc_pkg::*;

    localparam int RANDOM_PIXELS = 1500;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 6;
    localparam int EMPTY_LINE    = 3;

    // indexes past the two size registers; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum logic {ACT_WRITE, ACT_PIXEL} t_act;

    typedef struct packed {
        t_act                 kind;
        logic [CFG_IDX_W-1:0] index;
        logic [SIZE_W-1:0]    value;   // register data, or the pixel in bit 0
        logic                 typed;
        logic [COUNT_W-1:0]   count;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // [0] is_set, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;         // [12:0] isolated_count, [15:13] zero

    isolated_pixel_counter_core i_dut (.*);

    always #6 i_clk = ~i_clk;

    // model state
    bit                 line_bits [4][MAX_COLUMNS];
    logic [SIZE_W-1:0]  rows_reg = SIZE_W'(128);
    logic [SIZE_W-1:0]  cols_reg = SIZE_W'(128);
    int unsigned        next_col, next_row;
    logic [COUNT_W-1:0] tally;

    logic [COUNT_W-1:0] pending_counts [$];
    int                 mismatches, counts_checked, pixels_sent, writes_done;
    int                 gap_pct, stall_pct, quiet_cycles;
    bit                 steady, hold_request;

    t_plan_row DIRECTED_PLAN [37] = '{
        '{ACT_WRITE, REG_FRAME_ROWS,    8'd1,   1'b0, 13'd0},
        '{ACT_WRITE, REG_FRAME_COLUMNS, 8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b1, 13'd1},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b1, 13'd0},
        // zero sizes act as one
        '{ACT_WRITE, REG_FRAME_ROWS,    8'd0,   1'b0, 13'd0},
        '{ACT_WRITE, REG_FRAME_COLUMNS, 8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b1, 13'd1},
        '{ACT_WRITE, REG_SPARE_A,       8'd5,   1'b0, 13'd0},
        '{ACT_WRITE, REG_SPARE_B,       8'd255, 1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b1, 13'd1},
        '{ACT_WRITE, REG_FRAME_ROWS,    8'd2,   1'b0, 13'd0},
        '{ACT_WRITE, REG_FRAME_COLUMNS, 8'd2,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b1, 13'd1},
        // diagonal pair: neither is alone
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b1, 13'd0},
        '{ACT_WRITE, REG_FRAME_ROWS,    8'd3,   1'b0, 13'd0},
        '{ACT_WRITE, REG_FRAME_COLUMNS, 8'd3,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b1, 13'd4},
        // partial frame, dropped by the next write
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_WRITE, REG_FRAME_ROWS,    8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd0,   1'b0, 13'd0},
        '{ACT_PIXEL, 2'd0,              8'd1,   1'b1, 13'd2}
    };

    function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < 3; i++)
            for (int x = 0; x < MAX_COLUMNS; x++)
                line_bits[i][x] = 1'b0;
        next_col = 0;
        next_row = 0;
        tally    = '0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        case (idx)
            REG_FRAME_ROWS: begin
                rows_reg = value;
                restart_frame();
            end
            REG_FRAME_COLUMNS: begin
                cols_reg = value;
                restart_frame();
            end
            default: ;
        endcase
    endfunction

    function automatic bit neighbor(int line, int x, int width, int off);
        if (off < 0 && x == 0)
            return 1'b0;
        if (off > 0 && x + 1 >= width)
            return 1'b0;
        return line_bits[line][x + off];
    endfunction

    function automatic void judge_row(int up, int mid, int down, int width);
        bit alone;
        for (int x = 0; x < width; x++) begin
            if (line_bits[mid][x]) begin
                alone = 1'b1;
                for (int d = -1; d <= 1; d++) begin
                    if (neighbor(up, x, width, d) || neighbor(down, x, width, d))
                        alone = 1'b0;
                    if (d != 0 && neighbor(mid, x, width, d))
                        alone = 1'b0;
                end
                if (alone && tally < COUNT_LIMIT)
                    tally = tally + 1'b1;
            end
        end
    endfunction

    // Advance the model by one pixel; returns 1 when the frame count is due.
    function automatic bit count_pixel(bit value, output logic [COUNT_W-1:0] count);
        int unsigned rows, cols, cur, prev, prev2;
        rows  = clamp_size(rows_reg, MAX_ROWS);
        cols  = clamp_size(cols_reg, MAX_COLUMNS);
        cur   = next_row % 3;
        prev  = (next_row + 2) % 3;
        prev2 = (next_row + 1) % 3;
        count = '0;
        if (next_col >= cols)
            next_col = 0;
        line_bits[cur][next_col] = value;
        next_col++;
        if (next_col < cols)
            return 1'b0;
        next_col = 0;
        if (next_row >= 1)
            judge_row(next_row >= 2 ? prev2 : EMPTY_LINE, prev, cur, cols);
        if (next_row + 1 >= rows) begin
            judge_row(next_row >= 1 ? prev : EMPTY_LINE, cur, EMPTY_LINE, cols);
            count = tally;
            restart_frame();
            return 1'b1;
        end
        next_row++;
        return 1'b0;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid left high.
    task automatic offer_pixel(input bit value, input bit typed,
                               input logic [COUNT_W-1:0] typed_count);
        logic [COUNT_W-1:0] predicted;
        if (!steady && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, value};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pixels_sent++;
        if (count_pixel(value, predicted))
            pending_counts.push_back(typed ? typed_count : predicted);
        @(negedge i_clk);
    endtask

    // Stop the pixel stream and let the block drain before a register write.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_reg(idx, value);
        writes_done++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // count checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_counts.size() == 0) begin
                $error("unexpected count word: isolated_count actual %0d",
                       m_axis_tdata[COUNT_W-1:0]);
                mismatches++;
            end else begin
                if (m_axis_tdata[COUNT_W-1:0] !== pending_counts[0]) begin
                    $error("isolated_count mismatch: expected %0d actual %0d",
                           pending_counts[0], m_axis_tdata[COUNT_W-1:0]);
                    mismatches++;
                end
                void'(pending_counts.pop_front());
                counts_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (i_cfg_valid && o_cfg_ready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // count receiver: random stalls, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (!steady && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned rows_eff, cols_eff, frames, density, part, goal;
        logic [SIZE_W-1:0] rows_val, cols_val;
        bit hold_issued;
        bit hold_now;

        restart_frame();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == ACT_WRITE) begin
                settle();
                write_reg(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].value);
            end else begin
                offer_pixel(DIRECTED_PLAN[i].value[0], DIRECTED_PLAN[i].typed,
                            DIRECTED_PLAN[i].count);
            end
        end

        goal = pixels_sent + RANDOM_PIXELS;
        hold_issued = 1'b0;
        while (pixels_sent < goal) begin
            case ($urandom_range(0, 11))
                0: begin rows_val = 8'd1; cols_val = 8'($urandom_range(128, 255)); end
                1: begin rows_val = 8'($urandom_range(128, 255)); cols_val = 8'd1; end
                2: begin rows_val = 8'd0; cols_val = 8'($urandom_range(0, 8)); end
                3: begin rows_val = 8'($urandom_range(1, 3)); cols_val = 8'd0; end
                4: begin rows_val = 8'd2; cols_val = 8'd128; end
                default: begin
                    rows_val = 8'($urandom_range(1, 6));
                    cols_val = 8'($urandom_range(1, 8));
                end
            endcase
            // small frames back to back while the receiver holds off fill the block
            hold_now = !hold_issued && pixels_sent >= goal - RANDOM_PIXELS + 500;
            if (hold_now) begin
                rows_val = 8'd2;
                cols_val = 8'd3;
            end
            settle();
            if ($urandom_range(0, 1)) begin
                write_reg(REG_FRAME_ROWS, rows_val);
                write_reg(REG_FRAME_COLUMNS, cols_val);
            end else begin
                write_reg(REG_FRAME_COLUMNS, cols_val);
                write_reg(REG_FRAME_ROWS, rows_val);
            end
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          8'($urandom_range(0, 255)));

            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 5;
                default: gap_pct = 20;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 5;
                default: stall_pct = 20;
            endcase

            rows_eff = clamp_size(rows_val, MAX_ROWS);
            cols_eff = clamp_size(cols_val, MAX_COLUMNS);
            frames = (rows_eff * cols_eff > 64) ? 1 : $urandom_range(1, 4);
            if (hold_now) begin
                hold_issued  = 1'b1;
                hold_request = 1'b1;
                frames       = 4;
            end
            for (int f = 0; f < frames; f++) begin
                density = $urandom_range(1, 7);   // set odds in eighths
                for (int p = 0; p < rows_eff * cols_eff; p++) begin
                    if (pixels_sent >= goal - RANDOM_PIXELS / 6)
                        steady = 1'b1;
                    offer_pixel($urandom_range(1, 8) <= density, 1'b0, '0);
                end
            end
            // sometimes leave a frame half done for the next write to drop
            if (rows_eff * cols_eff > 1 && $urandom_range(0, 5) == 0) begin
                part = $urandom_range(1, rows_eff * cols_eff - 1);
                for (int p = 0; p < part; p++)
                    offer_pixel(1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_counts.size() != 0) begin
            $error("%0d frame counts never arrived", pending_counts.size());
            mismatches++;
        end

        $display("Covered %0d pixels and %0d register writes over frame shapes 1x1 to 128 wide",
                 pixels_sent, writes_done);
        $display("Compared %0d frame counts, %0d mismatches", counts_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
